// ----- rtl/bdm_pkg.sv -----
// Shared types, widths and codes of the barcode demultiplexing matcher.
package bdm_pkg;

   localparam int MAX_BARCODES = 64;
   localparam int MAX_BASES    = 16;
   localparam int MAX_MISMATCH = 3;

   localparam int BASE_BITS = 3;
   localparam int BASES_W   = 48;
   localparam int IDX_W     = $clog2(MAX_BARCODES);
   localparam int SCAN_W    = IDX_W + 1;
   localparam int DIST_W    = $clog2(MAX_BASES + 1);
   localparam int ENTRY_W   = 6;
   localparam int MM_W      = 2;
   localparam int LEN_W     = 5;
   localparam int NUM_W     = 7;
   localparam int RLEN_W    = 16;
   localparam int CNT_W     = 32;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 7;

   // Largest base code that is a real nucleotide (A, C, G, T); N and above are not.
   localparam logic [BASE_BITS-1:0] BASE_T = 3'd3;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_MATCH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_MATCH_WRITTEN  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MATCH_SHORT    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_MATCH       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_LOAD_OK        = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LOAD_DUPLICATE = 3'd4;
   localparam logic [STATUS_W-1:0] ST_LOAD_BAD_INDEX = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MISMATCHES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BARCODE_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BARCODES   = 2'd2;

   typedef struct packed {
      logic               opcode;
      logic [ENTRY_W-1:0] entry_index;
      logic [BASES_W-1:0] bases;
      logic [RLEN_W-1:0]  read_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENTRY_W-1:0]  barcode_index;
      logic [MM_W-1:0]     mismatch_count;
      logic [LEN_W-1:0]    trim_length;
      logic [RLEN_W-1:0]   remaining_length;
      logic [CNT_W-1:0]    hit_count;
   } rsp_type;

   typedef struct packed {
      logic [DIST_W-1:0] diff_count;
      logic              bad;
      logic              equal;
   } cmp_result_type;

endpackage

// ----- rtl/bdm_ram.sv -----
// Generic simple dual-port RAM with a registered read port.
module bdm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bdm_compare.sv -----
// Position-wise comparison of one stored barcode against the leading bases of a read.
module bdm_compare import bdm_pkg::*; (
   input  logic [BASES_W-1:0] stored,
   input  logic [BASES_W-1:0] read_bases,
   input  logic [LEN_W-1:0]   length,
   output cmp_result_type     result
);

   always_comb begin
      result.diff_count = '0;
      result.bad        = 1'b0;
      result.equal      = 1'b1;
      for (int i = 0; i < MAX_BASES; i++) begin
         if (i < int'(length)) begin
            if (stored[i*BASE_BITS +: BASE_BITS] != read_bases[i*BASE_BITS +: BASE_BITS]) begin
               result.equal      = 1'b0;
               result.diff_count = result.diff_count + DIST_W'(1);
               // A differing read base that is not a nucleotide rules the entry out.
               if (read_bases[i*BASE_BITS +: BASE_BITS] > BASE_T) begin
                  result.bad = 1'b1;
               end
            end
         end
      end
   end

endmodule

// ----- rtl/barcode_demux_matcher.sv -----
// Top level of the barcode demultiplexing matcher: sequencer, registers and memories.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_data (req_type)
//   rsp      out        rsp_valid/rsp_ready  rsp_data (rsp_type)
//   csr      in         csr_we               csr_index, csr_wdata
//
// A load beat scans all 64 table entries, one per cycle. A match beat scans the N
// entries in use (num_barcodes, at most 64); a hit then reads, increments and writes
// back the hit counter before its result is given, a miss skips the counter.
// The scan rate is set by the single read port of the barcode memory. The next beat is
// accepted once the result is registered and the sequencer is idle; rsp_ready low
// holds the result. Reset is synchronous; it clears the valid bits, the sequencer and
// the configuration registers but the barcode length, which it sets to 8.
// A finished result waits in the output register while the next beat is accepted.
module barcode_demux_matcher import bdm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CNT_RD,
      S_CNT_WR,
      S_RESP
   } state_type;

   // Configuration registers.
   logic [MM_W-1:0]  max_mm_ff, max_mm_in;
   logic [LEN_W-1:0] bc_len_ff, bc_len_in;
   logic [NUM_W-1:0] num_bc_ff, num_bc_in;

   // Sequencer and the beat under work.
   state_type          state_ff, state_in;
   logic               op_ff, op_in;
   logic [ENTRY_W-1:0] idx_ff, idx_in;
   logic [BASES_W-1:0] bases_ff, bases_in;
   logic [RLEN_W-1:0]  rlen_ff, rlen_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [MM_W-1:0]    limit_ff, limit_in;
   logic [SCAN_W-1:0]  end_ff, end_in;

   // Scan pipeline: the address issued, then the entry whose data has come back.
   logic [SCAN_W-1:0]  addr_ff, addr_in;
   logic               pv_ff, pv_in;
   logic [IDX_W-1:0]   pidx_ff, pidx_in;
   logic               pval_ff, pval_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   best_ff, best_in;
   logic [DIST_W-1:0]  bestd_ff, bestd_in;

   logic [MAX_BARCODES-1:0] entry_valid_ff, entry_valid_in;

   rsp_type res_ff, res_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // Memory ports.
   logic               store_we;
   logic [BASES_W-1:0] store_rdata;
   logic               cnt_we;
   logic [IDX_W-1:0]   cnt_waddr;
   logic [CNT_W-1:0]   cnt_wdata;
   logic [CNT_W-1:0]   cnt_rdata;

   // Combinational helpers.
   logic [LEN_W-1:0]   eff_len;
   logic [MM_W-1:0]    eff_limit;
   logic [SCAN_W-1:0]  eff_used;
   logic               issue;
   logic               scan_done;
   cmp_result_type     cmp;
   logic [CNT_W-1:0]   cnt_next;

   // The barcode table; an entry's data is only used once its valid bit says it was loaded.
   bdm_ram #(
      .WIDTH (BASES_W),
      .DEPTH (MAX_BARCODES)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (IDX_W'(idx_ff)),
      .wr_data (bases_ff),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (store_rdata)
   );

   // Hit counters; a load clears the counter of its entry when it marks it valid,
   // so a counter is never read before it has been written.
   bdm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_BARCODES)
   ) u_counters (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (best_ff),
      .rd_data (cnt_rdata)
   );

   bdm_compare u_compare (
      .stored     (store_rdata),
      .read_bases (bases_ff),
      .length     (len_ff),
      .result     (cmp)
   );

   // Out-of-range register values are clamped when a beat is taken.
   always_comb begin
      if (bc_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (32'(bc_len_ff) > 32'(MAX_BASES)) begin
         eff_len = LEN_W'(MAX_BASES);
      end else begin
         eff_len = bc_len_ff;
      end
      if (32'(max_mm_ff) > 32'(MAX_MISMATCH)) begin
         eff_limit = MM_W'(MAX_MISMATCH);
      end else begin
         eff_limit = max_mm_ff;
      end
      if (32'(num_bc_ff) > 32'(MAX_BARCODES)) begin
         eff_used = SCAN_W'(MAX_BARCODES);
      end else begin
         eff_used = SCAN_W'(num_bc_ff);
      end
   end

   assign issue     = (state_ff == S_SCAN) && (addr_ff < end_ff);
   assign scan_done = (state_ff == S_SCAN) && !issue && !pv_ff;
   assign cnt_next  = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + CNT_W'(1);

   // Configuration writes; an index beyond the register list is ignored.
   always_comb begin
      max_mm_in = max_mm_ff;
      bc_len_in = bc_len_ff;
      num_bc_in = num_bc_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_MISMATCHES: max_mm_in = csr_wdata[MM_W-1:0];
            CSR_BARCODE_LENGTH: bc_len_in = csr_wdata[LEN_W-1:0];
            CSR_NUM_BARCODES:   num_bc_in = csr_wdata[NUM_W-1:0];
            default:            ;
         endcase
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      idx_in         = idx_ff;
      bases_in       = bases_ff;
      rlen_in        = rlen_ff;
      len_in         = len_ff;
      limit_in       = limit_ff;
      end_in         = end_ff;
      addr_in        = addr_ff;
      pv_in          = 1'b0;
      pidx_in        = pidx_ff;
      pval_in        = pval_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      bestd_in       = bestd_ff;
      entry_valid_in = entry_valid_ff;
      res_in         = res_ff;
      store_we       = 1'b0;
      cnt_we         = 1'b0;
      cnt_waddr      = best_ff;
      cnt_wdata      = cnt_next;

      // The output register empties when its beat is taken.
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.opcode;
               idx_in   = req_data.entry_index;
               bases_in = req_data.bases;
               rlen_in  = req_data.read_length;
               len_in   = eff_len;
               limit_in = eff_limit;
               addr_in  = '0;
               found_in = 1'b0;
               best_in  = '0;
               bestd_in = '0;
               res_in   = '0;
               if (req_data.opcode == OP_LOAD) begin
                  // Duplicate search runs over the whole table.
                  end_in = SCAN_W'(MAX_BARCODES);
               end else if (req_data.read_length >= RLEN_W'(eff_len)) begin
                  end_in = eff_used;
               end else begin
                  // A read shorter than the barcode matches nothing.
                  end_in = '0;
               end
               if (req_data.opcode == OP_LOAD &&
                   32'(req_data.entry_index) >= 32'(MAX_BARCODES)) begin
                  res_in.status = ST_LOAD_BAD_INDEX;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            pv_in   = issue;
            pidx_in = addr_ff[IDX_W-1:0];
            pval_in = entry_valid_ff[addr_ff[IDX_W-1:0]];
            if (issue) begin
               addr_in = addr_ff + SCAN_W'(1);
            end

            // Evaluate the entry whose data is on the read port this cycle.
            if (pv_ff && pval_ff) begin
               if (op_ff == OP_LOAD) begin
                  if (32'(pidx_ff) != 32'(idx_ff) && cmp.equal && !found_ff) begin
                     found_in = 1'b1;
                     best_in  = pidx_ff;
                  end
               end else if (!cmp.bad && cmp.diff_count <= DIST_W'(limit_ff) &&
                            (!found_ff || cmp.diff_count < bestd_ff)) begin
                  // Strictly fewer mismatches only, so a tie keeps the lower index.
                  found_in = 1'b1;
                  best_in  = pidx_ff;
                  bestd_in = cmp.diff_count;
               end
            end

            if (scan_done) begin
               if (op_ff == OP_LOAD) begin
                  if (found_ff) begin
                     res_in.status        = ST_LOAD_DUPLICATE;
                     res_in.barcode_index = ENTRY_W'(best_ff);
                  end else begin
                     store_we                           = 1'b1;
                     entry_valid_in[IDX_W'(idx_ff)]     = 1'b1;
                     cnt_we                             = 1'b1;
                     cnt_waddr                          = IDX_W'(idx_ff);
                     cnt_wdata                          = '0;
                     res_in.status                      = ST_LOAD_OK;
                     res_in.barcode_index               = idx_ff;
                  end
                  state_in = S_RESP;
               end else if (found_ff) begin
                  state_in = S_CNT_RD;
               end else begin
                  res_in.status = ST_NO_MATCH;
                  state_in      = S_RESP;
               end
            end
         end

         S_CNT_RD: begin
            // The counter of the winning entry is being read.
            state_in = S_CNT_WR;
         end

         S_CNT_WR: begin
            cnt_we                = 1'b1;
            res_in.barcode_index  = ENTRY_W'(best_ff);
            res_in.mismatch_count = MM_W'(bestd_ff);
            res_in.trim_length    = len_ff;
            res_in.hit_count      = cnt_next;
            if (rlen_ff > RLEN_W'(len_ff)) begin
               res_in.status           = ST_MATCH_WRITTEN;
               res_in.remaining_length = rlen_ff - RLEN_W'(len_ff);
            end else begin
               res_in.status           = ST_MATCH_SHORT;
               res_in.remaining_length = '0;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_mm_ff      <= '0;
         bc_len_ff      <= LEN_W'(8);
         num_bc_ff      <= '0;
         state_ff       <= S_IDLE;
         pv_ff          <= 1'b0;
         found_ff       <= 1'b0;
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_mm_ff      <= max_mm_in;
         bc_len_ff      <= bc_len_in;
         num_bc_ff      <= num_bc_in;
         state_ff       <= state_in;
         pv_ff          <= pv_in;
         found_ff       <= found_in;
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      bases_ff    <= bases_in;
      rlen_ff     <= rlen_in;
      len_ff      <= len_in;
      limit_ff    <= limit_in;
      end_ff      <= end_in;
      addr_ff     <= addr_in;
      pidx_ff     <= pidx_in;
      pval_ff     <= pval_in;
      best_ff     <= best_in;
      bestd_ff    <= bestd_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- tb/sv/barcode_demux_matcher_tb.sv -----
// Self-checking testbench for the barcode demultiplexing matcher.
`timescale 1ns / 100ps

module barcode_demux_matcher_tb import bdm_pkg::*; ();

   // Register index past the end of the register list; the block must ignore writes to it.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam int RANDOM_PHASES   = 10;
   localparam int BEATS_PER_PHASE = 95;
   localparam int REPORT_CAP      = 40;
   localparam int POOL_DEPTH      = 64;

   // Directed barcodes and reads, three bits per base with base 0 in the lowest digit.
   localparam logic [BASES_W-1:0] BC_ALL_A       = 48'o0000_0000_0000_0000;
   localparam logic [BASES_W-1:0] BC_ALL_T       = 48'o3333_3333_3333_3333;
   localparam logic [BASES_W-1:0] BC_ALTERNATE   = 48'o1212_1212_1212_1212;
   localparam logic [BASES_W-1:0] BC_ODD_CODES   = 48'o7654_3210_0123_4567;
   localparam logic [BASES_W-1:0] BC_LEAD_C      = 48'o0000_0000_0000_0001;
   localparam logic [BASES_W-1:0] BC_LEAD_A_ONLY = 48'o0000_0000_0000_5550;
   localparam logic [BASES_W-1:0] RD_LEAD_G      = 48'o0000_0000_0000_0002;
   localparam logic [BASES_W-1:0] RD_LEAD_N      = 48'o0000_0000_0000_0004;
   localparam logic [BASES_W-1:0] RD_THREE_OFF   = 48'o0000_0000_0111_0000;
   localparam logic [BASES_W-1:0] RD_FOUR_OFF    = 48'o0000_0000_1111_0000;
   localparam logic [BASES_W-1:0] RD_ODD_SWAPPED = 48'o7654_3210_0123_4565;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   barcode_demux_matcher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Our own copy of the barcode table, the hit counters and the register file. The
   // table contents are only consulted for slots that have been loaded.
   bit [BASES_W-1:0]  tbl_bases  [MAX_BARCODES];
   bit                tbl_loaded [MAX_BARCODES];
   bit [CNT_W-1:0]    tbl_hits   [MAX_BARCODES];
   logic [MM_W-1:0]   cfg_mm  = '0;
   logic [LEN_W-1:0]  cfg_len = 5'd8;
   logic [NUM_W-1:0]  cfg_num = '0;

   req_type            req_backlog[$];      // beats waiting for the driver
   rsp_type            pending_outcomes[$]; // predicted results, oldest first
   logic [BASES_W-1:0] barcode_pool[$];     // barcodes sent for loading, used to build reads

   int  beats_queued   = 0;
   int  beats_accepted = 0;
   int  fault_count    = 0;
   int  report_count   = 0;
   int  loads_sent     = 0;
   int  matches_sent   = 0;
   int  settings_used  = 0;
   int  hits_seen      = 0;
   int  misses_seen    = 0;
   int  dups_seen      = 0;
   int  req_gap        = 0;
   int  rsp_hold       = 0;
   bit  req_taken      = 1'b0;
   bit  steady_req     = 1'b0;
   bit  steady_rsp     = 1'b0;

   // Free-running 100 MHz clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog, set several times over the slowest legal run.
   initial begin
      #10ms;
      $display("barcode_demux_matcher_tb failed");
      $finish;
   end

   // The block clamps a barcode length of zero up to one base and anything beyond the
   // table width down to MAX_BASES.
   function automatic int used_length(input logic [LEN_W-1:0] len_reg);
      if (len_reg == 0) return 1;
      if (len_reg > MAX_BASES) return MAX_BASES;
      return int'(len_reg);
   endfunction

   // Works out the result of one accepted beat and updates our copy of the state.
   function automatic rsp_type demux_outcome(input req_type beat);
      rsp_type                res;
      int                     len;
      int                     limit;
      int                     used;
      int                     diffs;
      int                     best;
      int                     best_d;
      bit                     rejected;
      logic [63:0]            span;
      logic [BASES_W-1:0]     mask;
      logic [BASE_BITS-1:0]   stored_code;
      logic [BASE_BITS-1:0]   read_code;
      res  = '0;
      len  = used_length(cfg_len);
      span = (64'd1 << (BASE_BITS * len)) - 64'd1;
      mask = span[BASES_W-1:0];

      if (beat.opcode == OP_LOAD) begin
         // A six-bit slot number can never reach MAX_BARCODES, so the bad-index outcome
         // cannot arise here. The duplicate search covers the whole table, whatever
         // num_barcodes says, and the slot being written does not count against itself.
         for (int i = 0; i < MAX_BARCODES; i++) begin
            if (i != beat.entry_index && tbl_loaded[i] &&
                ((tbl_bases[i] ^ beat.bases) & mask) == '0) begin
               res.status        = ST_LOAD_DUPLICATE;
               res.barcode_index = ENTRY_W'(i);
               return res;
            end
         end
         tbl_bases[beat.entry_index]  = beat.bases;
         tbl_loaded[beat.entry_index] = 1'b1;
         tbl_hits[beat.entry_index]   = '0;
         res.status        = ST_LOAD_OK;
         res.barcode_index = beat.entry_index;
         return res;
      end

      limit  = (int'(cfg_mm) > MAX_MISMATCH) ? MAX_MISMATCH : int'(cfg_mm);
      used   = (int'(cfg_num) > MAX_BARCODES) ? MAX_BARCODES : int'(cfg_num);
      best   = -1;
      best_d = 0;
      // A read shorter than the barcode cannot match at all.
      if (beat.read_length >= len) begin
         for (int i = 0; i < used; i++) begin
            if (tbl_loaded[i]) begin
               diffs    = 0;
               rejected = 1'b0;
               for (int p = 0; p < len; p++) begin
                  stored_code = tbl_bases[i][p*BASE_BITS +: BASE_BITS];
                  read_code   = beat.bases[p*BASE_BITS +: BASE_BITS];
                  // Identical codes agree even when they are N or above; a differing read
                  // base that is not a real nucleotide rules the entry out.
                  if (stored_code != read_code) begin
                     if (read_code > BASE_T) rejected = 1'b1;
                     diffs++;
                  end
               end
               // Strictly fewer differences wins, so ties go to the lowest slot.
               if (!rejected && diffs <= limit && (best < 0 || diffs < best_d)) begin
                  best   = i;
                  best_d = diffs;
               end
            end
         end
      end

      if (best < 0) begin
         res.status = ST_NO_MATCH;
         return res;
      end
      if (tbl_hits[best] != '1) tbl_hits[best]++;
      res.barcode_index  = ENTRY_W'(best);
      res.mismatch_count = MM_W'(best_d);
      res.trim_length    = LEN_W'(len);
      res.hit_count      = tbl_hits[best];
      // A read no longer than its barcode still counts as a hit but is not written out.
      if (beat.read_length > len) begin
         res.status           = ST_MATCH_WRITTEN;
         res.remaining_length = RLEN_W'(beat.read_length - len);
      end else begin
         res.status = ST_MATCH_SHORT;
      end
      return res;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         fault_count++;
         if (report_count < REPORT_CAP) begin
            report_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         end
      end
   endtask

   // Mostly short idles with the odd long one; none at all in a steady stretch.
   function automatic int pick_gap(input bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   // Request driver: presents the next queued beat at the falling edge once the previous
   // one has been taken, holding it steady until the block accepts it.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            req_data  <= req_backlog.pop_front();
            req_valid <= 1'b1;
            req_gap    = pick_gap(steady_req);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure: ready drops for random stretches regardless of rsp_valid.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_hold = pick_gap(steady_rsp);
      end
   end

   // Monitor: at each rising edge checks an accepted result beat against the oldest
   // prediction, then predicts the outcome of any request beat accepted at that edge.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               fault_count++;
               if (report_count < REPORT_CAP) begin
                  report_count++;
                  $display("%0t: result beat with nothing expected, got status %0d index %0d",
                           $time, rsp_data.status, rsp_data.barcode_index);
               end
            end else begin
               want = pending_outcomes.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("barcode_index", 64'(want.barcode_index),
                           64'(rsp_data.barcode_index));
               check_field("mismatch_count", 64'(want.mismatch_count),
                           64'(rsp_data.mismatch_count));
               check_field("trim_length", 64'(want.trim_length), 64'(rsp_data.trim_length));
               check_field("remaining_length", 64'(want.remaining_length),
                           64'(rsp_data.remaining_length));
               check_field("hit_count", 64'(want.hit_count), 64'(rsp_data.hit_count));
               case (want.status)
                  ST_MATCH_WRITTEN, ST_MATCH_SHORT: hits_seen++;
                  ST_NO_MATCH:                      misses_seen++;
                  ST_LOAD_DUPLICATE:                dups_seen++;
                  default: ;
               endcase
            end
         end
         if (req_valid && req_ready) begin
            pending_outcomes.push_back(demux_outcome(req_data));
            beats_accepted++;
         end
      end
      req_taken <= !reset && req_valid && req_ready;
   end

   // Mostly genuine nucleotides, with the occasional N or other non-ACGT code.
   function automatic logic [BASES_W-1:0] random_barcode();
      logic [BASES_W-1:0] bc;
      bc = '0;
      for (int p = 0; p < MAX_BASES; p++) begin
         if ($urandom_range(0, 19) == 0) bc[p*BASE_BITS +: BASE_BITS] = 3'($urandom_range(4, 7));
         else bc[p*BASE_BITS +: BASE_BITS] = 3'($urandom_range(0, 3));
      end
      return bc;
   endfunction

   // Builds a read from a known barcode with a few substitutions inside the compared
   // window, and sometimes scrambles the bases beyond it, which must be ignored.
   function automatic logic [BASES_W-1:0] mutate_read(input logic [BASES_W-1:0] src,
                                                       input int len, input int edits);
      logic [BASES_W-1:0]   rd;
      logic [63:0]          span;
      logic [BASE_BITS-1:0] code;
      int                   pos;
      rd = src;
      for (int k = 0; k < edits; k++) begin
         pos = $urandom_range(0, len - 1);
         if ($urandom_range(0, 6) == 0) code = 3'($urandom_range(4, 7));
         else code = {1'b0, 2'(rd[pos*BASE_BITS +: 2] + $urandom_range(1, 3))};
         rd[pos*BASE_BITS +: BASE_BITS] = code;
      end
      if ($urandom_range(0, 1) == 0) begin
         span = (64'd1 << (BASE_BITS * len)) - 64'd1;
         rd   = (rd & span[BASES_W-1:0]) |
                (BASES_W'({$urandom, $urandom}) & ~span[BASES_W-1:0]);
      end
      return rd;
   endfunction

   function automatic logic [RLEN_W-1:0] pick_read_length(input int len);
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 11) return RLEN_W'(len + $urandom_range(1, 300));
      if (roll < 13) return RLEN_W'(len);
      if (roll < 15) return RLEN_W'($urandom_range(0, len - 1));
      if (roll < 19) return RLEN_W'($urandom_range(0, 65535));
      return '1;
   endfunction

   task automatic send(input logic op, input int slot, input logic [BASES_W-1:0] bases,
                       input int rlen);
      req_type beat;
      beat.opcode      = op;
      beat.entry_index = ENTRY_W'(slot);
      beat.bases       = bases;
      beat.read_length = RLEN_W'(rlen);
      req_backlog.push_back(beat);
      beats_queued++;
      if (op == OP_LOAD) loads_sent++;
      else matches_sent++;
   endtask

   // Drives one register write at the falling edge and mirrors it in our register copy.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_MAX_MISMATCHES: cfg_mm  = data[MM_W-1:0];
         CSR_BARCODE_LENGTH: cfg_len = data[LEN_W-1:0];
         CSR_NUM_BARCODES:   cfg_num = data[NUM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_registers(input int mm, input int len, input int num,
                                    input bit touch_spare);
      write_register(CSR_MAX_MISMATCHES, CSR_DATA_W'(mm));
      write_register(CSR_BARCODE_LENGTH, CSR_DATA_W'(len));
      write_register(CSR_NUM_BARCODES, CSR_DATA_W'(num));
      if (touch_spare) write_register(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 127)));
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
      // New beats are queued on a rising edge so the driver never races the queue.
      @(posedge clock);
   endtask

   // Every beat gives exactly one result, so the block is idle once all queued beats
   // have been accepted and every prediction has been matched.
   task automatic wait_idle();
      while (beats_accepted != beats_queued || pending_outcomes.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_random_phase(input int beats);
      int                 mm;
      int                 len_set;
      int                 num_set;
      int                 eff;
      int                 slot_cap;
      int                 roll;
      int                 slot;
      logic [BASES_W-1:0] bc;
      mm   = $urandom_range(0, 3);
      roll = $urandom_range(0, 9);
      if (roll < 3) len_set = $urandom_range(1, 4);
      else if (roll < 7) len_set = $urandom_range(5, 16);
      else if (roll == 7) len_set = 0;
      else if (roll == 8) len_set = $urandom_range(17, 31);
      else len_set = MAX_BASES;
      roll = $urandom_range(0, 9);
      if (roll < 4) num_set = MAX_BARCODES;
      else if (roll < 5) num_set = $urandom_range(65, 127);
      else if (roll < 7) num_set = $urandom_range(0, 8);
      else num_set = $urandom_range(1, 63);
      steady_req = ($urandom_range(0, 3) == 0);
      steady_rsp = ($urandom_range(0, 3) == 0);
      program_registers(mm, len_set, num_set, $urandom_range(0, 3) == 0);

      eff      = used_length(LEN_W'(len_set));
      slot_cap = (num_set == 0 || num_set > MAX_BARCODES) ? MAX_BARCODES : num_set;
      // Each phase opens with loads so that the reads that follow have something to hit.
      for (int b = 0; b < beats; b++) begin
         if (b < 8 || $urandom_range(0, 9) < 3) begin
            roll = $urandom_range(0, 99);
            if (roll < 60 || barcode_pool.size() == 0) begin
               bc = random_barcode();
               barcode_pool.push_back(bc);
               if (barcode_pool.size() > POOL_DEPTH) void'(barcode_pool.pop_front());
            end else if (roll < 85) begin
               bc = barcode_pool[$urandom_range(0, barcode_pool.size() - 1)];
            end else begin
               bc = BASES_W'({$urandom, $urandom});
            end
            if ($urandom_range(0, 4) != 0) slot = $urandom_range(0, slot_cap - 1);
            else slot = $urandom_range(0, MAX_BARCODES - 1);
            send(OP_LOAD, slot, bc, $urandom_range(0, 65535));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 75 && barcode_pool.size() > 0)
               bc = mutate_read(barcode_pool[$urandom_range(0, barcode_pool.size() - 1)],
                                eff, $urandom_range(0, MAX_MISMATCH + 1));
            else if (roll < 88) bc = random_barcode();
            else bc = BASES_W'({$urandom, $urandom});
            send(OP_MATCH, $urandom_range(0, MAX_BARCODES - 1), bc, pick_read_length(eff));
         end
      end
      wait_idle();
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: no entries are in use, so even a freshly loaded barcode is missed.
      send(OP_MATCH, 0, BC_ALL_A, 40);
      send(OP_LOAD, 0, BC_ALTERNATE, 0);
      send(OP_MATCH, 0, BC_ALTERNATE, 40);
      wait_idle();

      // Widest window, loosest limit, whole table in use.
      program_registers(MAX_MISMATCH, MAX_BASES, MAX_BARCODES, 1'b0);
      send(OP_LOAD, 63, BC_ALL_A, 0);
      send(OP_LOAD, 1, BC_ALL_T, 0);
      send(OP_LOAD, 5, BC_ALL_A, 0);         // duplicate of the top slot, refused
      send(OP_LOAD, 63, BC_ALL_A, 0);        // same slot again is not a duplicate
      send(OP_LOAD, 2, BC_ODD_CODES, 0);
      send(OP_LOAD, 3, BC_LEAD_C, 0);
      send(OP_MATCH, 0, BC_ALL_A, 100);
      send(OP_MATCH, 0, RD_THREE_OFF, 100);  // exactly at the mismatch limit
      send(OP_MATCH, 0, RD_FOUR_OFF, 100);   // one past the limit
      send(OP_MATCH, 0, RD_LEAD_N, 100);     // N where the table differs never matches
      send(OP_MATCH, 0, BC_ODD_CODES, 100);  // equal non-ACGT codes still agree
      send(OP_MATCH, 0, RD_ODD_SWAPPED, 100);
      send(OP_MATCH, 0, RD_LEAD_G, 100);     // equal distance to two entries: lower wins
      send(OP_MATCH, 0, BC_ALL_A, 16);       // read no longer than the barcode
      send(OP_MATCH, 0, BC_ALL_A, 15);       // read shorter than the barcode
      send(OP_MATCH, 0, BC_ALL_A, 0);
      send(OP_MATCH, 0, BC_ALL_A, 65535);
      send(OP_MATCH, 0, BASES_W'({$urandom, $urandom}), $urandom_range(0, 65535));
      wait_idle();

      // A zero length behaves as one base; the entry count saturates at the table size.
      program_registers(0, 0, 127, 1'b0);
      send(OP_MATCH, 0, BC_ALL_T, 1);
      send(OP_LOAD, 10, BC_LEAD_A_ONLY, 0);
      wait_idle();

      // An oversized length behaves as the full window; the spare index is ignored.
      program_registers(1, 31, 2, 1'b1);
      send(OP_MATCH, 0, BC_ALL_T, 20);
      send(OP_MATCH, 0, BC_ALL_A, 20);
      wait_idle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) run_random_phase(BEATS_PER_PHASE);

      // Any stray result beat would show up in this window.
      repeat (80) @(negedge clock);
      $display("Sent %0d loads and %0d reads across %0d register settings.",
               loads_sent, matches_sent, settings_used);
      $display("Reads assigned %0d, unassigned %0d; duplicate loads refused %0d.",
               hits_seen, misses_seen, dups_seen);
      if (fault_count == 0 && pending_outcomes.size() == 0) begin
         $display("barcode_demux_matcher_tb passed");
      end else begin
         $display("barcode_demux_matcher_tb failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/bdm_pkg.sv
rtl/bdm_ram.sv
rtl/bdm_compare.sv
rtl/barcode_demux_matcher.sv
tb/sv/barcode_demux_matcher_tb.sv
